// ===== src/lkm_pkg.sv =====
// Shared constants and types for the limb Karatsuba multiplier.
// No dependencies; the top level and lkm_carry import this package.
package lkm_pkg;

    // Width and number of the limb fields on the ports.
    localparam int FIELD_BITS  = 26;
    localparam int FIELD_LIMBS = 5;

    typedef logic [FIELD_BITS-1:0] t_field;

endpackage

// ===== src/limb_karatsuba_multiplier.sv =====
// Top level of the pipelined multi-limb multiplier with its valid pipeline.
// Uses lkm_pkg, lkm_pp, lkm_colsum and lkm_carry.
//
//  Channel   Valid     Stall     Payload
//  input     i_valid   o_stall   i_a_limb0..4, i_b_limb0..4
//  output    o_valid   i_stall   o_p_limb0..9
//
// Five register stages: input capture, partial products, column sums, low-half
// carry add, high-half carry add. One transaction can be accepted every cycle
// while o_stall is low.
// The pipeline moves as a whole; it holds only while a result waits at the
// output under i_stall, so o_stall follows that condition in the same cycle.
// Reset clears the valid bits only.
module limb_karatsuba_multiplier #(
    parameter int LIMB_BITS  = 26,
    parameter int LIMB_COUNT = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  lkm_pkg::t_field  i_a_limb0,
    input  lkm_pkg::t_field  i_a_limb1,
    input  lkm_pkg::t_field  i_a_limb2,
    input  lkm_pkg::t_field  i_a_limb3,
    input  lkm_pkg::t_field  i_a_limb4,
    input  lkm_pkg::t_field  i_b_limb0,
    input  lkm_pkg::t_field  i_b_limb1,
    input  lkm_pkg::t_field  i_b_limb2,
    input  lkm_pkg::t_field  i_b_limb3,
    input  lkm_pkg::t_field  i_b_limb4,
    output logic             o_valid,
    input  logic             i_stall,
    output lkm_pkg::t_field  o_p_limb0,
    output lkm_pkg::t_field  o_p_limb1,
    output lkm_pkg::t_field  o_p_limb2,
    output lkm_pkg::t_field  o_p_limb3,
    output lkm_pkg::t_field  o_p_limb4,
    output lkm_pkg::t_field  o_p_limb5,
    output lkm_pkg::t_field  o_p_limb6,
    output lkm_pkg::t_field  o_p_limb7,
    output lkm_pkg::t_field  o_p_limb8,
    output lkm_pkg::t_field  o_p_limb9
);

    import lkm_pkg::*;

    localparam int STAGES   = 5;
    localparam int COL_BITS = LIMB_BITS + $clog2(2*LIMB_COUNT);
    localparam int EXT_BITS = (LIMB_BITS > FIELD_BITS) ? LIMB_BITS : FIELD_BITS;

    logic                 advance;
    t_field               a_field [FIELD_LIMBS];
    t_field               b_field [FIELD_LIMBS];
    logic [LIMB_BITS-1:0] n_x [LIMB_COUNT];
    logic [LIMB_BITS-1:0] n_y [LIMB_COUNT];

    logic [STAGES-1:0]    r_vld;
    logic [LIMB_BITS-1:0] r_x [LIMB_COUNT];
    logic [LIMB_BITS-1:0] r_y [LIMB_COUNT];

    logic [2*LIMB_BITS-1:0] pp  [LIMB_COUNT][LIMB_COUNT];
    logic [COL_BITS-1:0]    col [2*LIMB_COUNT];
    t_field                 prod [2*FIELD_LIMBS];

    assign advance = !(r_vld[STAGES-1] && i_stall);
    assign o_stall = !advance;
    assign o_valid = r_vld[STAGES-1];

    assign a_field = '{i_a_limb0, i_a_limb1, i_a_limb2, i_a_limb3, i_a_limb4};
    assign b_field = '{i_b_limb0, i_b_limb1, i_b_limb2, i_b_limb3, i_b_limb4};

    // Each field is masked or zero-padded to LIMB_BITS; limbs at or above
    // LIMB_COUNT are not used.
    for (genvar g = 0; g < LIMB_COUNT; g++) begin : g_in
        logic [EXT_BITS-1:0] a_ext;
        logic [EXT_BITS-1:0] b_ext;
        assign a_ext  = EXT_BITS'(a_field[g]);
        assign b_ext  = EXT_BITS'(b_field[g]);
        assign n_x[g] = a_ext[LIMB_BITS-1:0];
        assign n_y[g] = b_ext[LIMB_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (advance) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

    lkm_pp #(
        .LIMB_BITS  (LIMB_BITS),
        .LIMB_COUNT (LIMB_COUNT)
    ) u_pp (
        .i_clk (i_clk),
        .i_en  (advance),
        .i_x   (r_x),
        .i_y   (r_y),
        .o_pp  (pp)
    );

    lkm_colsum #(
        .LIMB_BITS  (LIMB_BITS),
        .LIMB_COUNT (LIMB_COUNT),
        .COL_BITS   (COL_BITS)
    ) u_colsum (
        .i_clk (i_clk),
        .i_en  (advance),
        .i_pp  (pp),
        .o_col (col)
    );

    lkm_carry #(
        .LIMB_BITS  (LIMB_BITS),
        .LIMB_COUNT (LIMB_COUNT),
        .COL_BITS   (COL_BITS)
    ) u_carry (
        .i_clk (i_clk),
        .i_en  (advance),
        .i_col (col),
        .o_p   (prod)
    );

    assign o_p_limb0 = prod[0];
    assign o_p_limb1 = prod[1];
    assign o_p_limb2 = prod[2];
    assign o_p_limb3 = prod[3];
    assign o_p_limb4 = prod[4];
    assign o_p_limb5 = prod[5];
    assign o_p_limb6 = prod[6];
    assign o_p_limb7 = prod[7];
    assign o_p_limb8 = prod[8];
    assign o_p_limb9 = prod[9];

endmodule

// ===== src/lkm_pp.sv =====
// Partial-product stage: one registered LIMB_BITS x LIMB_BITS multiplier per limb pair.
// Depends on nothing outside this file.
module lkm_pp #(
    parameter int LIMB_BITS  = 26,
    parameter int LIMB_COUNT = 5
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [LIMB_BITS-1:0]   i_x [LIMB_COUNT],
    input  logic [LIMB_BITS-1:0]   i_y [LIMB_COUNT],
    output logic [2*LIMB_BITS-1:0] o_pp [LIMB_COUNT][LIMB_COUNT]
);

    logic [2*LIMB_BITS-1:0] r_pp [LIMB_COUNT][LIMB_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < LIMB_COUNT; i++) begin
                for (int j = 0; j < LIMB_COUNT; j++) begin
                    r_pp[i][j] <= (2*LIMB_BITS)'(i_x[i]) * (2*LIMB_BITS)'(i_y[j]);
                end
            end
        end
    end

    assign o_pp = r_pp;

endmodule

// ===== src/lkm_colsum.sv =====
// Column-sum stage: gathers the low and high halves of all partial products
// into one registered sum per product limb position. Depends on nothing else.
module lkm_colsum #(
    parameter int LIMB_BITS  = 26,
    parameter int LIMB_COUNT = 5,
    parameter int COL_BITS   = LIMB_BITS + $clog2(2*LIMB_COUNT)
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [2*LIMB_BITS-1:0] i_pp [LIMB_COUNT][LIMB_COUNT],
    output logic [COL_BITS-1:0]    o_col [2*LIMB_COUNT]
);

    logic [COL_BITS-1:0] n_col [2*LIMB_COUNT];
    logic [COL_BITS-1:0] r_col [2*LIMB_COUNT];

    // Low half of pair (i, j) lands on column i+j, high half on column i+j+1.
    // Each column takes at most 2*LIMB_COUNT terms, which COL_BITS covers.
    always_comb begin
        for (int k = 0; k < 2*LIMB_COUNT; k++) begin
            n_col[k] = '0;
        end
        for (int i = 0; i < LIMB_COUNT; i++) begin
            for (int j = 0; j < LIMB_COUNT; j++) begin
                n_col[i+j]   = n_col[i+j]   + COL_BITS'(i_pp[i][j][LIMB_BITS-1:0]);
                n_col[i+j+1] = n_col[i+j+1] + COL_BITS'(i_pp[i][j][2*LIMB_BITS-1:LIMB_BITS]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_col <= n_col;
        end
    end

    assign o_col = r_col;

endmodule

// ===== src/lkm_carry.sv =====
// Carry-normalization stages: the column sums are resolved by a wide add split
// into a low half and a high half over two registers. Uses lkm_pkg.
module lkm_carry #(
    parameter int LIMB_BITS  = 26,
    parameter int LIMB_COUNT = 5,
    parameter int COL_BITS   = LIMB_BITS + $clog2(2*LIMB_COUNT)
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [COL_BITS-1:0]  i_col [2*LIMB_COUNT],
    output lkm_pkg::t_field      o_p [2*lkm_pkg::FIELD_LIMBS]
);

    import lkm_pkg::*;

    localparam int HALF_BITS = LIMB_COUNT * LIMB_BITS;
    localparam int WORD_BITS = 2 * HALF_BITS;
    localparam int EXT_BITS  = (LIMB_BITS > FIELD_BITS) ? LIMB_BITS : FIELD_BITS;

    logic [WORD_BITS-1:0] low_word;
    logic [WORD_BITS-1:0] carry_word;
    logic [HALF_BITS:0]   n_lo_sum;
    logic [HALF_BITS-1:0] n_hi_sum;

    logic [HALF_BITS:0]   r_lo_sum;
    logic [HALF_BITS-1:0] r_hi_a;
    logic [HALF_BITS-1:0] r_hi_b;
    logic [WORD_BITS-1:0] r_prod;

    // The low bits of every column stay in place; the excess of column k moves
    // up to limb k+1. The excess of the top column is always zero because the
    // product fits in 2*LIMB_COUNT limbs.
    always_comb begin
        low_word   = '0;
        carry_word = '0;
        for (int k = 0; k < 2*LIMB_COUNT; k++) begin
            low_word[k*LIMB_BITS +: LIMB_BITS] = i_col[k][LIMB_BITS-1:0];
        end
        for (int k = 0; k < 2*LIMB_COUNT - 1; k++) begin
            carry_word[(k+1)*LIMB_BITS +: LIMB_BITS] =
                LIMB_BITS'(i_col[k][COL_BITS-1:LIMB_BITS]);
        end
    end

    assign n_lo_sum = (HALF_BITS+1)'(low_word[HALF_BITS-1:0])
                    + (HALF_BITS+1)'(carry_word[HALF_BITS-1:0]);

    assign n_hi_sum = HALF_BITS'(r_hi_a + r_hi_b + HALF_BITS'(r_lo_sum[HALF_BITS]));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo_sum <= n_lo_sum;
            r_hi_a   <= low_word[WORD_BITS-1:HALF_BITS];
            r_hi_b   <= carry_word[WORD_BITS-1:HALF_BITS];
            r_prod   <= {n_hi_sum, r_lo_sum[HALF_BITS-1:0]};
        end
    end

    // Product limbs past 2*LIMB_COUNT are tied to zero; each limb is cut or
    // padded to the field width.
    for (genvar g = 0; g < 2*FIELD_LIMBS; g++) begin : g_out
        if (g < 2*LIMB_COUNT) begin : g_used
            logic [EXT_BITS-1:0] limb_ext;
            assign limb_ext = EXT_BITS'(r_prod[g*LIMB_BITS +: LIMB_BITS]);
            assign o_p[g]   = limb_ext[FIELD_BITS-1:0];
        end else begin : g_unused
            assign o_p[g] = '0;
        end
    end

endmodule
